// ===== sv/tsr_pkg.sv =====
// Shared types and constants for the typed stack with rotate.
// Holds field widths, action, status and tag codes, and controller/datapath structs.
// No dependencies.
package tsr_pkg;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 64;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 10;
   // Stored entry: cleanup mark, type tag, value.
   localparam int ENTRY_W  = VALUE_W + KIND_W + 1;

   localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_ROTATE = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_HEIGHT = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_SHALLOW = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_WRONG   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_BADTYPE = 3'd5;

   localparam logic [KIND_W-1:0] KIND_ANY  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CORO = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [VALUE_W-1:0]        push_value;
      logic [KIND_W-1:0]         entry_kind;
      logic                      cleanup_flag;
      logic signed [DEPTH_W-1:0] depth_or_count;
   } req_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec_done;
      logic read_issue;
      logic read_done;
      logic rot_start;
      logic rot_hold;
      logic rot_move;
      logic rot_last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                exec_error;
      logic                rot_trivial;
      logic                rot_more;
      logic                rsp_free;
   } dp_stat_type;

endpackage

// ===== sv/tsr_if.sv =====
// Valid/ready channel interfaces for the request and response sides of the stack.
// Depends on tsr_pkg for field widths.
interface tsr_req_if;
   import tsr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic [VALUE_W-1:0]        push_value;
   logic [KIND_W-1:0]         entry_kind;
   logic                      cleanup_flag;
   logic signed [DEPTH_W-1:0] depth_or_count;

   modport source (output valid, action, push_value, entry_kind, cleanup_flag,
                   depth_or_count, input ready);
   modport sink   (input valid, action, push_value, entry_kind, cleanup_flag,
                   depth_or_count, output ready);
endinterface

interface tsr_rsp_if #(parameter int HEIGHT_W = 9);
   import tsr_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  result_value;
   logic [KIND_W-1:0]   result_kind;
   logic                cleanup_due;
   logic [HEIGHT_W-1:0] height;
   logic [STATUS_W-1:0] status;

   modport source (output valid, result_value, result_kind, cleanup_due, height, status,
                   input ready);
   modport sink   (input valid, result_value, result_kind, cleanup_due, height, status,
                   output ready);
endinterface

// ===== sv/tsr_ctrl.sv =====
// Controller state machine of the typed stack: sequences decode, memory reads,
// rotate walk and response loading. Depends on tsr_pkg.
module tsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tsr_pkg::dp_stat_type stat,
   output tsr_pkg::dp_cmd_type  cmd
);
   import tsr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_RHOLD  = 3'd3;
   localparam logic [2:0] S_RMOVE  = 3'd4;
   localparam logic [2:0] S_RLAST  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.exec_error && (stat.action inside {ACT_POP, ACT_PEEK, ACT_READ})) begin
               cmd.read_issue = 1'b1;
               state_in       = S_RDWAIT;
            end else if (!stat.exec_error && stat.action == ACT_ROTATE &&
                         !stat.rot_trivial) begin
               cmd.rot_start = 1'b1;
               state_in      = S_RHOLD;
            end else if (stat.rsp_free) begin
               cmd.exec_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RDWAIT: begin
            if (stat.rsp_free) begin
               cmd.read_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RHOLD: begin
            cmd.rot_hold = 1'b1;
            state_in     = S_RMOVE;
         end
         S_RMOVE: begin
            cmd.rot_move = 1'b1;
            if (!stat.rot_more) begin
               state_in = S_RLAST;
            end
         end
         S_RLAST: begin
            if (stat.rsp_free) begin
               cmd.rot_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/tsr_dpath.sv =====
// Datapath of the typed stack: request register, entry memory, height counter,
// rotate pointer and response register. Depends on tsr_pkg.
module tsr_dpath #(
   parameter int STACK_DEPTH = 256,
   localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tsr_pkg::req_payload_type       req_payload,
   input  tsr_pkg::dp_cmd_type            cmd,
   output tsr_pkg::dp_stat_type           stat,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [tsr_pkg::VALUE_W-1:0]    result_value,
   output logic [tsr_pkg::KIND_W-1:0]     result_kind,
   output logic                           cleanup_due,
   output logic [CNT_W-1:0]               height,
   output logic [tsr_pkg::STATUS_W-1:0]   status
);
   import tsr_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int EW = ((CNT_W > DEPTH_W) ? CNT_W : DEPTH_W) + 1;

   req_payload_type     req_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ENTRY_W-1:0]  mem_ff [STACK_DEPTH];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [ENTRY_W-1:0]  hold_ff;
   logic [AW-1:0]       ptr_ff;
   logic [DEPTH_W-1:0]  rem_ff;
   logic                up_ff;

   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic                rsp_due_ff, rsp_due_in;
   logic [CNT_W-1:0]    rsp_height_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic signed [EW-1:0] d_ext, cnt_s, eff, slot_s;
   logic                 access_err;
   logic [AW-1:0]        access_slot;
   logic [DEPTH_W-1:0]   rot_n;
   logic                 rot_up, rot_trivial, rot_shallow, rot_more;
   logic [AW-1:0]        rot_start_slot, ptr_step, ptr_step2;
   logic [STATUS_W-1:0]  exec_status;
   logic                 push_ok, pop_wrong, rsp_free, rsp_load;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [KIND_W-1:0]    rd_kind;
   logic                 rd_clean;

   // Depth from the top; a negative depth counts from the bottom.
   always_comb begin
      d_ext = (req_ff.action == ACT_READ) ? EW'(req_ff.depth_or_count) : '0;
      cnt_s = signed'(EW'(count_ff));
      eff   = (d_ext < 0) ? d_ext + cnt_s : d_ext;
      access_err  = (eff < 0) || (eff >= cnt_s);
      slot_s      = cnt_s - eff - EW'(1);
      access_slot = slot_s[AW-1:0];
   end

   always_comb begin
      rot_up = req_ff.depth_or_count[DEPTH_W-1];
      rot_n  = rot_up ? unsigned'(-req_ff.depth_or_count) : unsigned'(req_ff.depth_or_count);
      rot_trivial = rot_n <= DEPTH_W'(1);
      rot_shallow = EW'(rot_n) > EW'(count_ff);
      rot_start_slot = rot_up ? AW'(EW'(count_ff) - EW'(rot_n)) :
                                AW'(count_ff - CNT_W'(1));
      rot_more  = rem_ff > DEPTH_W'(1);
      ptr_step  = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
      ptr_step2 = up_ff ? ptr_step + AW'(1) : ptr_step - AW'(1);
   end

   always_comb begin
      exec_status = STAT_OK;
      case (req_ff.action)
         ACT_PUSH: begin
            if (req_ff.entry_kind == KIND_ANY) begin
               exec_status = STAT_BADTYPE;
            end else if (count_ff == CNT_W'(STACK_DEPTH)) begin
               exec_status = STAT_FULL;
            end
         end
         ACT_POP, ACT_PEEK, ACT_READ: begin
            if (access_err) begin
               exec_status = STAT_EMPTY;
            end
         end
         ACT_ROTATE: begin
            if (!rot_trivial && rot_shallow) begin
               exec_status = STAT_SHALLOW;
            end
         end
         default: begin
            exec_status = STAT_OK;
         end
      endcase
   end

   assign rd_kind  = rd_data_ff[VALUE_W +: KIND_W];
   assign rd_clean = rd_data_ff[ENTRY_W-1];
   assign pop_wrong = (req_ff.action == ACT_POP) && (req_ff.entry_kind != KIND_ANY) &&
                      (rd_kind != req_ff.entry_kind);
   assign push_ok  = cmd.exec_done && (req_ff.action == ACT_PUSH) && (exec_status == STAT_OK);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = cmd.exec_done || cmd.read_done || cmd.rot_last;

   assign stat.action      = req_ff.action;
   assign stat.exec_error  = exec_status != STAT_OK;
   assign stat.rot_trivial = rot_trivial;
   assign stat.rot_more    = rot_more;
   assign stat.rsp_free    = rsp_free;

   // Memory port selection.
   always_comb begin
      rd_en   = cmd.read_issue || cmd.rot_start || cmd.rot_hold || (cmd.rot_move && rot_more);
      rd_addr = access_slot;
      if (cmd.rot_start) begin
         rd_addr = rot_start_slot;
      end else if (cmd.rot_hold) begin
         rd_addr = ptr_step;
      end else if (cmd.rot_move) begin
         rd_addr = ptr_step2;
      end
      wr_en   = push_ok || cmd.rot_move || cmd.rot_last;
      wr_addr = ptr_ff;
      wr_data = cmd.rot_last ? hold_ff : rd_data_ff;
      if (push_ok) begin
         wr_addr = count_ff[AW-1:0];
         wr_data = {req_ff.cleanup_flag, req_ff.entry_kind, req_ff.push_value};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.read_done && (req_ff.action == ACT_POP) && !pop_wrong) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_value_in  = '0;
      rsp_kind_in   = KIND_ANY;
      rsp_due_in    = 1'b0;
      rsp_status_in = STAT_OK;
      if (cmd.exec_done) begin
         rsp_status_in = exec_status;
      end else if (cmd.read_done) begin
         if (pop_wrong) begin
            rsp_status_in = STAT_WRONG;
         end else begin
            rsp_value_in = rd_data_ff[VALUE_W-1:0];
            rsp_kind_in  = rd_kind;
            rsp_due_in   = (req_ff.action == ACT_POP) && rd_clean && (rd_kind != KIND_CORO);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.rot_start) begin
         ptr_ff <= rot_start_slot;
         rem_ff <= rot_n - DEPTH_W'(1);
         up_ff  <= rot_up;
      end else if (cmd.rot_move) begin
         ptr_ff <= ptr_step;
         rem_ff <= rem_ff - DEPTH_W'(1);
      end
      if (cmd.rot_hold) begin
         hold_ff <= rd_data_ff;
      end
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_due_ff    <= rsp_due_in;
         rsp_height_ff <= count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign result_value = rsp_value_ff;
   assign result_kind  = rsp_kind_ff;
   assign cleanup_due  = rsp_due_ff;
   assign height       = rsp_height_ff;
   assign status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack height beyond capacity");

   a_rot_ptr_live: assert property (@(posedge clock) disable iff (reset)
      cmd.rot_move |-> (CNT_W'(ptr_ff) < count_ff))
      else $error("rotate walk left the live entries");

   a_count_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec_done || cmd.read_done) |=> $stable(count_ff))
      else $error("height changed outside a finishing step");

   a_rot_walk_done: assert property (@(posedge clock) disable iff (reset)
      cmd.rot_last |-> (rem_ff == '0))
      else $error("rotate finished with moves outstanding");
`endif

endmodule

// ===== sv/typed_stack_with_rotate.sv =====
// Typed stack with rotate: push, height, unused codes and failed checks end in the execute
// state; pop, peek and read (a pop of the wrong type too) add a memory read and its wait
// state; a rotate of N entries walks them with one memory read and one write per cycle.
// Results load once the output register is free. The next request transfer is taken right
// after the result is loaded, while that result still waits in the output register.
// Reset clears the height and empties the response register; entry memory is not cleared.
module typed_stack_with_rotate #(
   parameter int STACK_DEPTH = 256
) (
   input logic       clock,
   input logic       reset,
   tsr_req_if.sink   req_chan,
   tsr_rsp_if.source rsp_chan
);
   import tsr_pkg::*;

   // The controller owns the request handshake and steps the datapath through each
   // action; the datapath owns the entry memory, the height and the result register.
   req_payload_type req_payload;
   dp_cmd_type      cmd;
   dp_stat_type     stat;

   // Request fields are sampled into the datapath on the transfer cycle.
   assign req_payload.action         = req_chan.action;
   assign req_payload.push_value     = req_chan.push_value;
   assign req_payload.entry_kind     = req_chan.entry_kind;
   assign req_payload.cleanup_flag   = req_chan.cleanup_flag;
   assign req_payload.depth_or_count = req_chan.depth_or_count;

   tsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The result register decouples the response side: a result waits there until its
   // transfer while the controller already takes the next request.
   tsr_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .result_value (rsp_chan.result_value),
      .result_kind  (rsp_chan.result_kind),
      .cleanup_due  (rsp_chan.cleanup_due),
      .height       (rsp_chan.height),
      .status       (rsp_chan.status)
   );

endmodule

// ===== tb/sv/tb_typed_stack_with_rotate.sv =====
// Self-checking testbench for typed_stack_with_rotate: a directed table, then random traffic.
// Results are checked against an in-bench model of the stack, driven through valid/ready channels.
// Depends on tsr_pkg, tsr_if and the typed_stack_with_rotate RTL.
module tb_typed_stack_with_rotate;
   import tsr_pkg::*;

   localparam int STACK_DEPTH      = 256;
   localparam int HEIGHT_W         = 9;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int SETTLE_CYCLES    = 300;
   localparam int TIMEOUT_CYCLES   = 1000000;

   // Action codes that the block does not use; they must leave the stack alone.
   localparam logic [ACTION_W-1:0] ACT_UNUSED_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_B = 3'd7;

   localparam logic [KIND_W-1:0] KIND_INT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FLOAT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OBJECT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEST   = 3'd6;

   localparam logic [VALUE_W-1:0] VAL_ZERO     = '0;
   localparam logic [VALUE_W-1:0] VAL_ALL_ONES = '1;
   localparam logic [VALUE_W-1:0] VAL_TOP_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] VAL_CHECKER  = 64'h5555_5555_5555_5555;

   typedef struct packed {
      logic [VALUE_W-1:0]  result_value;
      logic [KIND_W-1:0]   result_kind;
      logic                cleanup_due;
      logic [HEIGHT_W-1:0] height;
      logic [STATUS_W-1:0] status;
   } stack_result_type;

   typedef struct {
      req_payload_type  req;
      bit               typed;
      stack_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsr_req_if                      req_chan ();
   tsr_rsp_if #(.HEIGHT_W(HEIGHT_W)) rsp_chan ();

   typed_stack_with_rotate #(.STACK_DEPTH(STACK_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The model's copy of the stack. Index 0 is the bottom slot; the top entry
   // sits at slot model_height - 1, exactly as the block lays out its memory.
   logic [VALUE_W-1:0] model_values [STACK_DEPTH];
   logic [KIND_W-1:0]  model_kinds  [STACK_DEPTH];
   logic               model_marks  [STACK_DEPTH];
   int                 model_height = 0;

   // Results that the block still owes, oldest first.
   stack_result_type   pending_results [$];
   directed_row_type   directed_rows   [$];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  peak_height     = 0;
   int  cleanups_due    = 0;
   int  status_seen [8] = '{default: 0};
   bit  sender_steady   = 1'b0;
   bit  receiver_steady = 1'b0;
   bit  long_hold_request = 1'b0;
   int  long_holds_done = 0;

   always #1 clock = ~clock;

   // Works out the result of one request and applies its effect to the model.
   function automatic stack_result_type predict_stack_result(input req_payload_type r);
      stack_result_type res;
      int sdc, d, n, i, top;
      logic [VALUE_W-1:0] held_value;
      logic [KIND_W-1:0]  held_kind;
      logic               held_mark;
      res = '0;
      sdc = $signed(r.depth_or_count);
      case (r.action)
         ACT_PUSH: begin
            if (r.entry_kind == KIND_ANY) begin
               res.status = STAT_BADTYPE;
            end else if (model_height >= STACK_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               model_values[model_height] = r.push_value;
               model_kinds[model_height]  = r.entry_kind;
               model_marks[model_height]  = r.cleanup_flag;
               model_height++;
            end
         end
         ACT_POP: begin
            if (model_height == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               top = model_height - 1;
               // A nonzero expected tag must match the top entry, or nothing moves.
               if (r.entry_kind != KIND_ANY && model_kinds[top] != r.entry_kind) begin
                  res.status = STAT_WRONG;
               end else begin
                  res.result_value = model_values[top];
                  res.result_kind  = model_kinds[top];
                  // Coroutine marks never ask for cleanup, whatever their mark says.
                  res.cleanup_due  = model_marks[top] && model_kinds[top] != KIND_CORO;
                  model_height--;
               end
            end
         end
         ACT_PEEK, ACT_READ: begin
            d = (r.action == ACT_PEEK) ? 0 : sdc;
            // A negative depth counts up from the bottom of this stack.
            if (d < 0) d += model_height;
            if (d < 0 || d >= model_height) begin
               res.status = STAT_EMPTY;
            end else begin
               res.result_value = model_values[model_height - 1 - d];
               res.result_kind  = model_kinds[model_height - 1 - d];
            end
         end
         ACT_ROTATE: begin
            // Counts of -1, 0 and 1 are no-ops with a good status.
            if (sdc < -1 || sdc > 1) begin
               n = (sdc < 0) ? -sdc : sdc;
               top = model_height - 1;
               if (n > model_height) begin
                  res.status = STAT_SHALLOW;
               end else if (sdc > 0) begin
                  // The top sinks to depth n-1; the entries above it rise by one.
                  held_value = model_values[top];
                  held_kind  = model_kinds[top];
                  held_mark  = model_marks[top];
                  for (i = 0; i < n - 1; i++) begin
                     model_values[top - i] = model_values[top - i - 1];
                     model_kinds[top - i]  = model_kinds[top - i - 1];
                     model_marks[top - i]  = model_marks[top - i - 1];
                  end
                  model_values[top - n + 1] = held_value;
                  model_kinds[top - n + 1]  = held_kind;
                  model_marks[top - n + 1]  = held_mark;
               end else begin
                  // The entry at depth n-1 rises to the top; the ones above it sink by one.
                  held_value = model_values[top - n + 1];
                  held_kind  = model_kinds[top - n + 1];
                  held_mark  = model_marks[top - n + 1];
                  for (i = n - 1; i > 0; i--) begin
                     model_values[top - i] = model_values[top - i + 1];
                     model_kinds[top - i]  = model_kinds[top - i + 1];
                     model_marks[top - i]  = model_marks[top - i + 1];
                  end
                  model_values[top] = held_value;
                  model_kinds[top]  = held_kind;
                  model_marks[top]  = held_mark;
               end
            end
         end
         default: begin
            // Height and the unused codes only report the height.
         end
      endcase
      res.height = HEIGHT_W'(model_height);
      status_seen[res.status]++;
      if (res.cleanup_due) cleanups_due++;
      if (model_height > peak_height) peak_height = model_height;
      return res;
   endfunction

   function automatic void add_row(input logic [ACTION_W-1:0] action,
                                   input logic [VALUE_W-1:0] value,
                                   input logic [KIND_W-1:0] kind, input logic clean,
                                   input int depth, input bit typed,
                                   input logic [VALUE_W-1:0] want_value,
                                   input logic [KIND_W-1:0] want_kind, input logic want_due,
                                   input int want_height, input logic [STATUS_W-1:0] want_status);
      directed_row_type row;
      row.req.action         = action;
      row.req.push_value     = value;
      row.req.entry_kind     = kind;
      row.req.cleanup_flag   = clean;
      row.req.depth_or_count = DEPTH_W'(depth);
      row.typed              = typed;
      row.want.result_value  = want_value;
      row.want.result_kind   = want_kind;
      row.want.cleanup_due   = want_due;
      row.want.height        = HEIGHT_W'(want_height);
      row.want.status        = want_status;
      directed_rows.push_back(row);
   endfunction

   // Draws one request. Most requests are shaped by the model's state so that they
   // get past the error checks; a share of pure noise covers every field bit and the
   // unused action codes.
   function automatic req_payload_type draw_request(input int push_pct, input int pop_pct);
      req_payload_type r;
      int pick, n, lim;
      r.action         = ACT_HEIGHT;
      r.push_value     = {$urandom, $urandom};
      r.entry_kind     = KIND_W'($urandom_range(1, 7));
      r.cleanup_flag   = 1'($urandom_range(0, 1));
      r.depth_or_count = '0;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         r.action         = ACTION_W'($urandom);
         r.entry_kind     = KIND_W'($urandom);
         r.depth_or_count = DEPTH_W'($urandom);
      end else if (pick < 12 + push_pct) begin
         r.action = ACT_PUSH;
      end else if (pick < 12 + push_pct + pop_pct) begin
         r.action = ACT_POP;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r.entry_kind = KIND_ANY;
            6, 7, 8: if (model_height > 0) r.entry_kind = model_kinds[model_height - 1];
            default: r.entry_kind = KIND_W'($urandom);
         endcase
      end else begin
         case ($urandom_range(0, 5))
            0: r.action = ACT_PEEK;
            1, 2: begin
               r.action = ACT_READ;
               if (model_height > 0 && $urandom_range(0, 9) < 5)
                  r.depth_or_count = DEPTH_W'($urandom_range(0, model_height - 1));
               else if (model_height > 0 && $urandom_range(0, 9) < 8)
                  r.depth_or_count = DEPTH_W'(-int'($urandom_range(1, model_height)));
               else
                  r.depth_or_count = DEPTH_W'($urandom);
            end
            3, 4: begin
               r.action = ACT_ROTATE;
               if (model_height >= 2) begin
                  lim = (model_height < 6) ? model_height : 6;
                  case ($urandom_range(0, 9))
                     0: n = $urandom_range(2, model_height);
                     1: n = model_height + 1;
                     default: n = $urandom_range(2, lim);
                  endcase
                  if ($urandom_range(0, 1)) n = -n;
               end else begin
                  n = int'($urandom_range(0, 4)) - 2;
               end
               r.depth_or_count = DEPTH_W'(n);
            end
            default: r.action = ACT_HEIGHT;
         endcase
      end
      return r;
   endfunction

   // Offers one request and waits for its transfer. The expectation is queued in the
   // same time step as the transfer, well before the result can come back.
   task automatic offer_request(input req_payload_type r, input bit typed,
                                input stack_result_type typed_want);
      int gap;
      stack_result_type predicted;
      if ($urandom_range(0, 31) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.action         <= r.action;
      req_chan.push_value     <= r.push_value;
      req_chan.entry_kind     <= r.entry_kind;
      req_chan.cleanup_flag   <= r.cleanup_flag;
      req_chan.depth_or_count <= r.depth_or_count;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_stack_result(r);
      pending_results.push_back(typed ? typed_want : predicted);
      items_sent++;
   endtask

   task automatic check_field(input string what, input logic [VALUE_W-1:0] expected,
                              input logic [VALUE_W-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, expected, actual);
         error_count++;
      end
   endtask

   // Checks every result transfer against the oldest outstanding expectation.
   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual value %h status %0d",
                     $time, rsp_chan.result_value, rsp_chan.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            check_field("result_value", want.result_value, rsp_chan.result_value);
            check_field("result_kind", VALUE_W'(want.result_kind), VALUE_W'(rsp_chan.result_kind));
            check_field("cleanup_due", VALUE_W'(want.cleanup_due), VALUE_W'(rsp_chan.cleanup_due));
            check_field("height", VALUE_W'(want.height), VALUE_W'(rsp_chan.height));
            check_field("status", VALUE_W'(want.status), VALUE_W'(rsp_chan.status));
         end
      end
   end

   // Result receiver. It stalls for a random number of cycles before each transfer,
   // sometimes not at all for a while, and once holds off for a long stretch so that
   // the block's output register stays full and its input side backs up.
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
            long_holds_done++;
         end else begin
            stall = receiver_steady ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         taken++;
         if (taken % 37 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      end
   end

   // Main sequence: reset, the directed table, then random phases.
   initial begin
      int full_before, drain_wait, directed_count;
      req_chan.valid          = 1'b0;
      req_chan.action         = ACT_HEIGHT;
      req_chan.push_value     = '0;
      req_chan.entry_kind     = KIND_ANY;
      req_chan.cleanup_flag   = 1'b0;
      req_chan.depth_or_count = '0;

      // The directed table. Rows marked typed carry their result by hand; the others
      // go through the model. The first rows run on the empty stack after reset.
      //      action      value         kind         cl    depth typed value     kind      due  h status
      add_row(ACT_POP,    VAL_ZERO,     KIND_ANY,    1'b0,    0, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_EMPTY);
      add_row(ACT_PEEK,   VAL_ZERO,     KIND_ANY,    1'b0,    0, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_EMPTY);
      add_row(ACT_HEIGHT, VAL_ZERO,     KIND_ANY,    1'b0,    0, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_PUSH,   VAL_ALL_ONES, KIND_ANY,    1'b1,    0, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_BADTYPE);
      add_row(ACT_ROTATE, VAL_ZERO,     KIND_ANY,    1'b0,    1, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      // Four entries: a coroutine mark with its cleanup mark set at the bottom.
      add_row(ACT_PUSH,   VAL_ALL_ONES, KIND_CORO,   1'b1,    0, 1, VAL_ZERO,    KIND_ANY, 0, 1, STAT_OK);
      add_row(ACT_PUSH,   VAL_ZERO,     KIND_INT,    1'b1,    0, 1, VAL_ZERO,    KIND_ANY, 0, 2, STAT_OK);
      add_row(ACT_PUSH,   VAL_TOP_BIT,  KIND_OBJECT, 1'b0,    0, 1, VAL_ZERO,    KIND_ANY, 0, 3, STAT_OK);
      add_row(ACT_PUSH,   VAL_CHECKER,  KIND_DEST,   1'b1,    0, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_OK);
      add_row(ACT_PEEK,   VAL_ZERO,     KIND_ANY,    1'b0,    0, 1, VAL_CHECKER, KIND_DEST, 0, 4, STAT_OK);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0,    3, 1, VAL_ALL_ONES, KIND_CORO, 0, 4, STAT_OK);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0,   -4, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0,    4, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_EMPTY);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0,   -5, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_EMPTY);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0,  511, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_EMPTY);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0, -512, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_EMPTY);
      add_row(ACT_ROTATE, VAL_ZERO,     KIND_ANY,    1'b0,    4, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_READ,   VAL_ZERO,     KIND_ANY,    1'b0,    3, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_ROTATE, VAL_ZERO,     KIND_ANY,    1'b0,   -4, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_ROTATE, VAL_ZERO,     KIND_ANY,    1'b0,   -1, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_ROTATE, VAL_ZERO,     KIND_ANY,    1'b0,    5, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_SHALLOW);
      add_row(ACT_POP,    VAL_ZERO,     KIND_FLOAT,  1'b0,    0, 1, VAL_ZERO,    KIND_ANY, 0, 4, STAT_WRONG);
      add_row(ACT_POP,    VAL_ZERO,     KIND_DEST,   1'b0,    0, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_POP,    VAL_ZERO,     KIND_ANY,    1'b0,    0, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_POP,    VAL_ZERO,     KIND_ANY,    1'b0,    0, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_POP,    VAL_ZERO,     KIND_CORO,   1'b0,    0, 0, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_UNUSED_A, VAL_ALL_ONES, KIND_CORO, 1'b1,   -1, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);
      add_row(ACT_UNUSED_B, VAL_ALL_ONES, KIND_CORO, 1'b1,   -1, 1, VAL_ZERO,    KIND_ANY, 0, 0, STAT_OK);

      // Synchronous reset, then release with valid still low before the table starts.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      directed_count = items_sent;

      // Mixed traffic at low heights.
      repeat (30) offer_request(draw_request(40, 30), 1'b0, '0);

      // Fill the stack to the top while the receiver holds off for a long stretch,
      // then keep pushing until several pushes have bounced off the full stack.
      long_hold_request = 1'b1;
      full_before = status_seen[STAT_FULL];
      while (status_seen[STAT_FULL] < full_before + 3)
         offer_request(draw_request(88, 0), 1'b0, '0);

      // Deep reads and wide rotates near the top, then a pop-heavy stretch down.
      repeat (20) offer_request(draw_request(10, 10), 1'b0, '0);
      repeat (30) offer_request(draw_request(5, 75), 1'b0, '0);

      // A short run of balanced traffic to finish.
      repeat (15) offer_request(draw_request(35, 40), 1'b0, '0);

      req_chan.valid <= 1'b0;

      // Let every outstanding result arrive, then give stray results time to show up.
      drain_wait = 0;
      while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
                  $time, pending_results.size(), pending_results.size());
         error_count++;
      end

      $display("Run covered %0d requests (%0d from the table) and %0d checked results; peak height %0d of %0d, long holds %0d.",
               items_sent, directed_count, results_checked, peak_height, STACK_DEPTH,
               long_holds_done);
      $display("Statuses seen: ok %0d, empty %0d, full %0d, shallow %0d, wrong %0d, bad type %0d; cleanups due %0d.",
               status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
               status_seen[STAT_SHALLOW], status_seen[STAT_WRONG], status_seen[STAT_BADTYPE],
               cleanups_due);
      if (error_count == 0) begin
         $display("** typed_stack_with_rotate: PASSED **");
      end else begin
         $display("** typed_stack_with_rotate: FAILED **");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      #(2 * TIMEOUT_CYCLES);
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_results.size());
      $display("** typed_stack_with_rotate: FAILED **");
      $finish;
   end

endmodule
